// ===== hdl/cif_pkg.sv =====
// ----------------------------------------------------------------------------
// cif_pkg
// Shared types and constants of the circular integer fifo: request layouts,
// operation codes, controller states and default sizes.
// ----------------------------------------------------------------------------
package cif_pkg;

    // default number of ring entries
    localparam int DEPTH_DEF = 1024;

    // fixed field widths
    localparam int DATA_W = 32;
    localparam int OCC_W  = 11;
    localparam int OP_W   = 2;

    // operation codes, the unused code acts as a query
    localparam logic [OP_W-1:0] OP_NONE = 2'd0;
    localparam logic [OP_W-1:0] OP_PUSH = 2'd1;
    localparam logic [OP_W-1:0] OP_POP  = 2'd2;

    // input request
    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic signed [DATA_W-1:0] push_value;
    } t_in_req;

    // result request
    typedef struct packed {
        logic                     pop_valid;
        logic signed [DATA_W-1:0] pop_value;
        logic                     underflow;
        logic                     overflow;
        logic [OCC_W-1:0]         occupancy;
        logic                     is_empty;
        logic                     front_valid;
        logic signed [DATA_W-1:0] front_value;
        logic signed [DATA_W-1:0] back_value;
    } t_out_req;

    // controller states
    typedef enum logic [0:0] {
        ST_IDLE,
        ST_FILL
    } t_state;

endpackage

// ===== hdl/cif_ram.sv =====
// ----------------------------------------------------------------------------
// cif_ram
// Entry storage: one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module cif_ram #(
    parameter int DEPTH = cif_pkg::DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [AW-1:0]                i_waddr,
    input  logic signed [cif_pkg::DATA_W-1:0] i_wdata,
    input  logic [AW-1:0]                i_raddr,
    output logic signed [cif_pkg::DATA_W-1:0] o_rdata
);

    logic signed [cif_pkg::DATA_W-1:0] r_mem [DEPTH];
    logic signed [cif_pkg::DATA_W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/cif_ctrl.sv =====
// ----------------------------------------------------------------------------
// cif_ctrl
// Ring pointers, entry count and cached front and back entries. Builds one
// result per request; a successful pop reads the new front in the fill state.
// ----------------------------------------------------------------------------
module cif_ctrl #(
    parameter int DEPTH = cif_pkg::DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  cif_pkg::t_in_req             i_req,
    output logic                         o_idle,
    output logic                         o_res_load,
    output cif_pkg::t_out_req            o_res,
    output logic                         o_we,
    output logic [AW-1:0]                o_waddr,
    output logic signed [cif_pkg::DATA_W-1:0] o_wdata,
    output logic [AW-1:0]                o_raddr,
    input  logic signed [cif_pkg::DATA_W-1:0] i_rdata
);

    cif_pkg::t_state r_state, n_state;
    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_tail, n_tail;
    logic [CW-1:0] r_count, n_count;
    logic signed [cif_pkg::DATA_W-1:0] r_front, n_front;
    logic signed [cif_pkg::DATA_W-1:0] r_back, n_back;
    logic signed [cif_pkg::DATA_W-1:0] r_pop_value, n_pop_value;

    logic [AW-1:0] head_inc;
    logic [AW-1:0] tail_inc;
    logic          full;
    logic          empty;

    // ring increments with wrap at the last entry
    assign head_inc = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + AW'(1);
    assign tail_inc = (r_tail == AW'(DEPTH - 1)) ? '0 : r_tail + AW'(1);
    assign full     = (r_count == CW'(DEPTH));
    assign empty    = (r_count == '0);

    // memory ports
    assign o_waddr = r_tail;
    assign o_wdata = i_req.push_value;
    assign o_raddr = head_inc;
    assign o_idle  = (r_state == cif_pkg::ST_IDLE);

    // control state and pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cif_pkg::ST_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    // cached entries
    always_ff @(posedge i_clk) begin
        r_front     <= n_front;
        r_back      <= n_back;
        r_pop_value <= n_pop_value;
    end

    // next state and result
    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_front     = r_front;
        n_back      = r_back;
        n_pop_value = r_pop_value;
        o_we        = 1'b0;
        o_res_load  = 1'b0;
        o_res       = '0;

        case (r_state)
            cif_pkg::ST_IDLE: begin
                if (i_accept) begin
                    case (i_req.op)
                        cif_pkg::OP_PUSH: begin
                            if (full) begin
                                o_res.overflow = 1'b1;
                            end else begin
                                o_we    = 1'b1;
                                n_tail  = tail_inc;
                                n_count = r_count + CW'(1);
                                n_back  = i_req.push_value;
                                if (empty) begin
                                    n_front = i_req.push_value;
                                end
                            end
                        end
                        cif_pkg::OP_POP: begin
                            if (empty) begin
                                o_res.underflow = 1'b1;
                            end else begin
                                n_pop_value = r_front;
                                n_head      = head_inc;
                                n_count     = r_count - CW'(1);
                                n_state     = cif_pkg::ST_FILL;
                            end
                        end
                        default: begin
                        end
                    endcase
                    // successful pops report from the fill state
                    o_res_load        = (n_state == cif_pkg::ST_IDLE);
                    o_res.occupancy   = cif_pkg::OCC_W'(n_count);
                    o_res.is_empty    = (n_count == '0);
                    o_res.front_valid = (n_count != '0);
                    o_res.front_value = (n_count != '0) ? n_front : '0;
                    o_res.back_value  = (n_count != '0) ? n_back : '0;
                end
            end
            cif_pkg::ST_FILL: begin
                // new front entry arrives from memory
                n_state           = cif_pkg::ST_IDLE;
                o_res_load        = 1'b1;
                if (!empty) begin
                    n_front = i_rdata;
                end
                o_res.pop_valid   = 1'b1;
                o_res.pop_value   = r_pop_value;
                o_res.occupancy   = cif_pkg::OCC_W'(r_count);
                o_res.is_empty    = empty;
                o_res.front_valid = !empty;
                o_res.front_value = empty ? '0 : i_rdata;
                o_res.back_value  = empty ? '0 : r_back;
            end
            default: begin
                n_state = cif_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/circular_int_fifo_top.sv =====
// ----------------------------------------------------------------------------
// circular_int_fifo_top
// Ring-buffer fifo of signed 32-bit integers: push, pop or query per request,
// one status result per request, held in an output register.
//
//   channel | signals                              | direction
//   --------+--------------------------------------+----------
//   input   | i_in_valid, o_in_ready, i_in_data    | in
//   output  | o_out_valid, i_out_ready, o_out_data | out
//
// Push, query, overflow and underflow requests finish in the idle state; a
// pop that removes an entry also passes through the fill state, which waits
// on the registered read of the entry memory for the new front entry.
// A new request is taken while a result waits if that result leaves in the
// same cycle. Reset clears pointers and count; entry storage is not cleared.
// ----------------------------------------------------------------------------
module circular_int_fifo_top #(
    parameter int DEPTH = cif_pkg::DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  cif_pkg::t_in_req  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output cif_pkg::t_out_req o_out_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic              idle;
    logic              accept;
    logic              res_load;
    cif_pkg::t_out_req res;
    logic              we;
    logic [AW-1:0]     waddr;
    logic [AW-1:0]     raddr;
    logic signed [cif_pkg::DATA_W-1:0] wdata;
    logic signed [cif_pkg::DATA_W-1:0] rdata;

    logic              r_out_valid, n_out_valid;
    cif_pkg::t_out_req r_out_data;

    // take a request when idle and the output slot frees up
    assign o_in_ready = idle && (!r_out_valid || i_out_ready);
    assign accept     = i_in_valid && o_in_ready;

    cif_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_req      (i_in_data),
        .o_idle     (idle),
        .o_res_load (res_load),
        .o_res      (res),
        .o_we       (we),
        .o_waddr    (waddr),
        .o_wdata    (wdata),
        .o_raddr    (raddr),
        .i_rdata    (rdata)
    );

    cif_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // output register occupancy
    always_comb begin
        if (res_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_out_data <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ===== test/circular_int_fifo_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// circular_int_fifo_top_tb
// Self-checking bench for the circular integer fifo. A short directed table
// covers reset state, extremes, underflow and the unused op code. Random
// traffic then fills the ring past full, drains it past empty, and mixes
// requests at full rate. Every result is compared field by field against its
// typed table row or an in-bench ring predictor. Both channels stall at
// random, with one long receiver hold-off.
// ----------------------------------------------------------------------------
module circular_int_fifo_top_tb;

    localparam int FIFO_DEPTH   = cif_pkg::DEPTH_DEF;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE_CYCLES = 20;

    // unused op code, behaves as a query
    localparam logic [cif_pkg::OP_W-1:0] OP_SPARE = 2'd3;

    localparam logic signed [cif_pkg::DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [cif_pkg::DATA_W-1:0] VAL_MIN = 32'sh8000_0000;

    typedef struct {
        cif_pkg::t_in_req  req;
        bit                has_exp;
        cif_pkg::t_out_req exp;
    } t_dir_row;

    logic              i_clk      = 1'b0;
    logic              i_rst_n    = 1'b0;
    logic              in_valid   = 1'b0;
    logic              in_ready;
    cif_pkg::t_in_req  in_data    = '0;
    logic              out_valid;
    logic              out_ready  = 1'b0;
    cif_pkg::t_out_req out_data;

    // predictor state
    logic signed [cif_pkg::DATA_W-1:0] ring_mem [FIFO_DEPTH];
    int ring_head = 0;
    int ring_tail = 0;
    int ring_cnt  = 0;

    cif_pkg::t_out_req status_q [$];
    t_dir_row dir_rows [$];

    int err_cnt     = 0;
    int n_sent      = 0;
    int n_checked   = 0;
    int n_overflow  = 0;
    int n_underflow = 0;
    int peak_occ    = 0;
    int cyc_cnt     = 0;

    int src_idle_pct = 25;
    int snk_idle_pct = 86;
    bit hold_armed   = 1'b0;
    bit hold_done    = 1'b0;
    int hold_left    = 0;

    circular_int_fifo_top #(
        .DEPTH(FIFO_DEPTH)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cyc_cnt <= cyc_cnt + 1;
        if (cyc_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cyc_cnt, status_q.size());
            $display("** circular_int_fifo_top: FAILED **");
            $finish;
        end
    end

    // status for a typed row, empty flag follows occupancy
    function automatic cif_pkg::t_out_req status(bit pv,
                                                 logic signed [cif_pkg::DATA_W-1:0] pval,
                                                 bit uf, bit of, int occ, bit fv,
                                                 logic signed [cif_pkg::DATA_W-1:0] front,
                                                 logic signed [cif_pkg::DATA_W-1:0] back);
        cif_pkg::t_out_req s;
        s.pop_valid   = pv;
        s.pop_value   = pval;
        s.underflow   = uf;
        s.overflow    = of;
        s.occupancy   = cif_pkg::OCC_W'(occ);
        s.is_empty    = (occ == 0);
        s.front_valid = fv;
        s.front_value = front;
        s.back_value  = back;
        return s;
    endfunction

    // advance the ring by one request and return its status
    function automatic cif_pkg::t_out_req next_status(cif_pkg::t_in_req r);
        cif_pkg::t_out_req s;
        s = '0;
        if (r.op == cif_pkg::OP_PUSH) begin
            if (ring_cnt >= FIFO_DEPTH) begin
                s.overflow = 1'b1;
                n_overflow++;
            end else begin
                ring_mem[ring_tail] = r.push_value;
                ring_tail = (ring_tail + 1 == FIFO_DEPTH) ? 0 : ring_tail + 1;
                ring_cnt++;
            end
        end else if (r.op == cif_pkg::OP_POP) begin
            if (ring_cnt == 0) begin
                s.underflow = 1'b1;
                n_underflow++;
            end else begin
                s.pop_valid = 1'b1;
                s.pop_value = ring_mem[ring_head];
                ring_head = (ring_head + 1 == FIFO_DEPTH) ? 0 : ring_head + 1;
                ring_cnt--;
            end
        end
        s.occupancy = cif_pkg::OCC_W'(ring_cnt);
        s.is_empty  = (ring_cnt == 0);
        if (ring_cnt != 0) begin
            s.front_valid = 1'b1;
            s.front_value = ring_mem[ring_head];
            // back entry sits just before the tail, wrapping at index zero
            s.back_value  = ring_mem[(ring_tail == 0) ? FIFO_DEPTH - 1 : ring_tail - 1];
        end
        if (ring_cnt > peak_occ)
            peak_occ = ring_cnt;
        return s;
    endfunction

    // random payload, biased toward extremes and small values
    function automatic logic signed [cif_pkg::DATA_W-1:0] rand_value();
        logic [cif_pkg::DATA_W-1:0] v;
        case ($urandom_range(7))
            0: v = VAL_MAX;
            1: v = VAL_MIN;
            2: v = '1;
            3: v = cif_pkg::DATA_W'($urandom_range(255));
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // weighted op pick, the rest split between query codes
    function automatic logic [cif_pkg::OP_W-1:0] pick_op(int push_w, int pop_w);
        int r;
        r = $urandom_range(99);
        if (r < push_w)
            return cif_pkg::OP_PUSH;
        if (r < push_w + pop_w)
            return cif_pkg::OP_POP;
        return r[0] ? OP_SPARE : cif_pkg::OP_NONE;
    endfunction

    task automatic cmp_field(string name, longint exp_v, longint got_v);
        if (exp_v != got_v) begin
            $error("%s: expected %0d, actual %0d", name, exp_v, got_v);
            err_cnt++;
        end
    endtask

    // offer one request, wait for the handshake, record its expected status
    task automatic send_req(cif_pkg::t_in_req r, bit has_exp, cif_pkg::t_out_req given);
        cif_pkg::t_out_req s;
        while ($urandom_range(99) < src_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= r;
        do @(posedge i_clk); while (!in_ready);
        s = next_status(r);
        status_q.push_back(has_exp ? given : s);
        n_sent++;
    endtask

    task automatic send_rand(int push_w, int pop_w);
        cif_pkg::t_in_req r;
        r.op         = pick_op(push_w, pop_w);
        r.push_value = rand_value();
        send_req(r, 1'b0, '0);
    endtask

    task automatic add_row(logic [cif_pkg::OP_W-1:0] op,
                           logic signed [cif_pkg::DATA_W-1:0] val,
                           bit has_exp, cif_pkg::t_out_req exp);
        t_dir_row row;
        row.req.op         = op;
        row.req.push_value = val;
        row.has_exp        = has_exp;
        row.exp            = exp;
        dir_rows.push_back(row);
    endtask

    // result side: check each accepted result, then pick next ready
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (status_q.size() == 0) begin
                    $error("result with no request waiting");
                    err_cnt++;
                end else begin
                    cif_pkg::t_out_req e;
                    e = status_q.pop_front();
                    cmp_field("pop_valid", e.pop_valid, out_data.pop_valid);
                    cmp_field("pop_value", e.pop_value, out_data.pop_value);
                    cmp_field("underflow", e.underflow, out_data.underflow);
                    cmp_field("overflow", e.overflow, out_data.overflow);
                    cmp_field("occupancy", e.occupancy, out_data.occupancy);
                    cmp_field("is_empty", e.is_empty, out_data.is_empty);
                    cmp_field("front_valid", e.front_valid, out_data.front_valid);
                    cmp_field("front_value", e.front_value, out_data.front_value);
                    cmp_field("back_value", e.back_value, out_data.back_value);
                    n_checked++;
                end
            end
            // one long hold-off so the block backs up into its input
            if (hold_armed && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    // stimulus
    initial begin
        // directed table: reset state, extremes, underflow, query codes
        add_row(cif_pkg::OP_NONE, 0,       1, status(0, 0, 0, 0, 0, 0, 0, 0));
        add_row(cif_pkg::OP_POP,  0,       1, status(0, 0, 1, 0, 0, 0, 0, 0));
        add_row(cif_pkg::OP_PUSH, VAL_MAX, 1,
                status(0, 0, 0, 0, 1, 1, VAL_MAX, VAL_MAX));
        add_row(cif_pkg::OP_PUSH, VAL_MIN, 1,
                status(0, 0, 0, 0, 2, 1, VAL_MAX, VAL_MIN));
        add_row(OP_SPARE,         -1,      1,
                status(0, 0, 0, 0, 2, 1, VAL_MAX, VAL_MIN));
        add_row(cif_pkg::OP_POP,  -1,      1,
                status(1, VAL_MAX, 0, 0, 1, 1, VAL_MIN, VAL_MIN));
        add_row(cif_pkg::OP_POP,  0,       1, status(1, VAL_MIN, 0, 0, 0, 0, 0, 0));
        add_row(cif_pkg::OP_POP,  VAL_MAX, 1, status(0, 0, 1, 0, 0, 0, 0, 0));
        add_row(cif_pkg::OP_PUSH, -1,      0, '0);
        add_row(cif_pkg::OP_PUSH, 0,       0, '0);
        add_row(cif_pkg::OP_PUSH, 1,       0, '0);
        add_row(cif_pkg::OP_PUSH, 32'sh5555_5555, 0, '0);
        add_row(cif_pkg::OP_PUSH, 32'shAAAA_AAAA, 0, '0);
        add_row(cif_pkg::OP_NONE, 32'sh1234_5678, 0, '0);
        add_row(cif_pkg::OP_POP,  0,       0, '0);
        add_row(OP_SPARE,         0,       0, '0);
        add_row(cif_pkg::OP_POP,  0,       0, '0);
        add_row(cif_pkg::OP_PUSH, 32'sh8000_0001, 0, '0);
        add_row(cif_pkg::OP_POP,  0,       0, '0);
        add_row(cif_pkg::OP_POP,  0,       0, '0);
        add_row(cif_pkg::OP_POP,  0,       0, '0);
        add_row(cif_pkg::OP_POP,  0,       0, '0);
        add_row(cif_pkg::OP_POP,  0,       1, status(0, 0, 1, 0, 0, 0, 0, 0));

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i])
            send_req(dir_rows[i].req, dir_rows[i].has_exp, dir_rows[i].exp);

        // mixed traffic near empty
        repeat (20)
            send_rand(50, 40);

        // fill past full while the receiver holds off for a while
        hold_armed <= 1'b1;
        while (ring_cnt < FIFO_DEPTH)
            send_rand(100, 0);
        repeat (12)
            send_rand(80, 0);

        // let every outstanding result come back, then swap idling
        in_valid <= 1'b0;
        while (status_q.size() != 0)
            @(posedge i_clk);
        src_idle_pct = 86;
        snk_idle_pct <= 25;

        // drain the first half with a slow sender
        while (ring_cnt > FIFO_DEPTH / 2)
            send_rand(0, 100);

        // full rate, no idling on either side: drain past empty, then mix
        src_idle_pct = 0;
        snk_idle_pct <= 0;
        while (ring_cnt > 0)
            send_rand(0, 100);
        repeat (10)
            send_rand(0, 70);
        repeat (30)
            send_rand(50, 45);

        in_valid <= 1'b0;
        while (status_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("covered %0d requests and %0d results, peak occupancy %0d of %0d",
                 n_sent, n_checked, peak_occ, FIFO_DEPTH);
        $display("overflowed pushes %0d, underflowed pops %0d", n_overflow, n_underflow);
        if (err_cnt == 0) begin
            $display("** circular_int_fifo_top: PASSED **");
        end else begin
            $display("%0d mismatches", err_cnt);
            $display("** circular_int_fifo_top: FAILED **");
        end
        $finish;
    end

endmodule

// ===== circular_int_fifo_top.f =====
hdl/cif_pkg.sv
hdl/cif_ram.sv
hdl/cif_ctrl.sv
hdl/circular_int_fifo_top.sv
test/circular_int_fifo_top_tb.sv
